>>> rtl/mts_pkg.sv
// Package for the min-tracking stack: beat structs, shift control, codes.
// No dependencies; imported by every module of the block.
package mts_pkg;

    localparam int DATA_W              = 32;
    localparam int DEFAULT_STACK_DEPTH = 256;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    // Command beat
    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] push_value;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     stack_empty;
        logic [1:0]               status;
    } t_result;

    // Shift control shared by every cell of a chain
    typedef struct packed {
        logic push;   // shift toward the bottom, new value enters cell 0
        logic pop;    // shift toward the top
    } t_shift;

endpackage

>>> rtl/mts_cell.sv
// One stack cell: a data word that takes its upper or lower neighbor's word.
// Depends on mts_pkg.
module mts_cell (
    input  logic                         i_clk,
    input  mts_pkg::t_shift              i_shift,
    input  logic [mts_pkg::DATA_W-1:0]   i_above,
    input  logic [mts_pkg::DATA_W-1:0]   i_below,
    output logic [mts_pkg::DATA_W-1:0]   o_data
);
    import mts_pkg::*;

    logic [DATA_W-1:0] r_data;

    // Payload only, no reset: content is undefined until pushed in
    always_ff @(posedge i_clk) begin
        if (i_shift.push) begin
            r_data <= i_above;
        end else if (i_shift.pop) begin
            r_data <= i_below;
        end
    end

    assign o_data = r_data;

endmodule

>>> rtl/mts_chain.sv
// A row of mts_cell forming a shift stack; cell 0 is the top.
// Depends on mts_pkg and mts_cell.
module mts_chain #(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                         i_clk,
    input  mts_pkg::t_shift              i_shift,
    input  logic [mts_pkg::DATA_W-1:0]   i_new,
    output logic [mts_pkg::DATA_W-1:0]   o_top,
    output logic [mts_pkg::DATA_W-1:0]   o_next
);
    import mts_pkg::*;

    logic [DATA_W-1:0] w_data [STACK_DEPTH];

    // Each cell sees its two neighbors; the ends see the new value and zero
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_above;
        logic [DATA_W-1:0] w_below;
        if (g == 0) begin : g_first
            assign w_above = i_new;
        end else begin : g_mid
            assign w_above = w_data[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_below = '0;
        end else begin : g_inner
            assign w_below = w_data[g+1];
        end
        mts_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_above (w_above),
            .i_below (w_below),
            .o_data  (w_data[g])
        );
    end

    assign o_top  = w_data[0];
    assign o_next = w_data[1];

endmodule

>>> rtl/min_tracking_stack_top.sv
// Top level of the min-tracking stack: counts, step decode, result register.
// Depends on mts_pkg and two mts_chain instances (values, minimums).
//
// Usage:
//   Command channel: a beat (i_cmd: kind, push_value) is taken at a rising
//   edge with start high and busy low. busy is low whenever reset is
//   released, so one push or pop may be issued every cycle.
//   Result channel: exactly one result beat per command, on o_result with
//   o_strobe high for one cycle, in the cycle after the command edge.
//   Throughput is 1 command per cycle; this is set by the cell chains, where a
//   push or pop shifts every cell of a chain by one place at the command edge
//   and the next command sees the new tops directly.
//   The receiver cannot stall: a result is valid for its strobe cycle only.
//   Reset (i_rst_n low, synchronous) empties both stacks by clearing the
//   counts; cell contents are left as they are and never read when stale.
//   A pop on an empty stack and a push on a full one change nothing and
//   report their status code.
module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mts_pkg::t_cmd     i_cmd,
    output logic              o_strobe,
    output mts_pkg::t_result  o_result
);
    import mts_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    logic [CNT_W-1:0] r_val_count, n_val_count;
    logic [CNT_W-1:0] r_min_count, n_min_count;
    logic             r_strobe;
    t_result          r_result, n_result;

    logic                     w_accept;
    t_shift                   w_val_shift, w_min_shift;
    logic signed [DATA_W-1:0] w_val_top, w_val_next;
    logic signed [DATA_W-1:0] w_min_top, w_min_next;
    logic signed [DATA_W-1:0] w_min_after;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // Step decode: shifts, new counts and the result beat
    always_comb begin
        w_val_shift  = '0;
        w_min_shift  = '0;
        n_val_count  = r_val_count;
        n_min_count  = r_min_count;
        n_result     = '0;
        n_result.status = ST_OK;
        w_min_after  = w_min_top;
        if (w_accept) begin
            if (i_cmd.kind == OP_PUSH) begin
                if (r_val_count == FULL_CNT) begin
                    n_result.status = ST_PUSH_FULL;
                end else begin
                    w_val_shift.push = 1'b1;
                    n_val_count      = r_val_count + 1'b1;
                    if (r_min_count == '0 || i_cmd.push_value <= w_min_top) begin
                        w_min_shift.push = 1'b1;
                        n_min_count      = r_min_count + 1'b1;
                        w_min_after      = i_cmd.push_value;
                    end
                end
            end else begin
                if (r_val_count == '0) begin
                    n_result.status = ST_POP_EMPTY;
                end else begin
                    w_val_shift.pop       = 1'b1;
                    n_val_count           = r_val_count - 1'b1;
                    n_result.popped_value = w_val_top;
                    if (r_min_count != '0 && w_val_top == w_min_top) begin
                        w_min_shift.pop = 1'b1;
                        n_min_count     = r_min_count - 1'b1;
                        w_min_after     = w_min_next;
                    end
                end
            end
        end
        n_result.stack_empty = (n_val_count == '0);
        n_result.min_value   = (n_val_count == '0 || n_min_count == '0) ? '0 : w_min_after;
    end

    // Value and minimum chains
    mts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_val_chain (
        .i_clk   (i_clk),
        .i_shift (w_val_shift),
        .i_new   (i_cmd.push_value),
        .o_top   (w_val_top),
        .o_next  (w_val_next)
    );

    mts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_min_chain (
        .i_clk   (i_clk),
        .i_shift (w_min_shift),
        .i_new   (i_cmd.push_value),
        .o_top   (w_min_top),
        .o_next  (w_min_next)
    );

    // Counts and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_count <= '0;
            r_min_count <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_val_count <= n_val_count;
            r_min_count <= n_min_count;
            r_strobe    <= w_accept;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Second entry of the value chain is not needed for any step
    logic w_unused;
    assign w_unused = ^w_val_next;

endmodule

>>> rtl/mts_checker.sv
// Port-level checker for min_tracking_stack_top, attached by bind.
// Depends on mts_pkg.
module mts_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  mts_pkg::t_cmd     i_cmd,
    input  logic              o_strobe,
    input  mts_pkg::t_result  o_result
);
    import mts_pkg::*;

    // Every accepted command gives one result beat in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("result beat missing after command");

    // No result beat without a command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result beat without command");

    // Pop on empty reports an empty stack with zero values
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_POP_EMPTY) |->
        (o_result.stack_empty && o_result.popped_value == '0 && o_result.min_value == '0))
        else $error("bad pop-on-empty result");

    // Empty stack shows zero minimum; push on full shows a nonempty stack, zero popped value
    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.stack_empty) |-> (o_result.min_value == '0))
        else $error("nonzero minimum on empty stack");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_PUSH_FULL) |->
        (!o_result.stack_empty && o_result.popped_value == '0))
        else $error("bad push-on-full result");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
